### rtl/core/qvr_pkg.sv
// shared defaults for the quaternion vector rotate pipeline
package qvr_pkg;

    localparam int COMP_WIDTH_DEF     = 16;
    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int LANES              = 3;

endpackage

### rtl/core/qvr_sat.sv
// saturation of one rescaled component to the output width
module qvr_sat #(
    parameter int ACC_W  = 3 * qvr_pkg::COMP_WIDTH_DEF + 5,
    parameter int COMP_W = qvr_pkg::COMP_WIDTH_DEF
) (
    input  logic signed [ACC_W-1:0]  i_value,
    output logic signed [COMP_W-1:0] o_value,
    output logic                     o_clip
);

    localparam logic signed [ACC_W-1:0] MAX_V =
        {{(ACC_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN_V =
        {{(ACC_W-COMP_W+1){1'b1}}, {(COMP_W-1){1'b0}}};

    always_comb begin
        if (i_value > MAX_V) begin
            o_value = MAX_V[COMP_W-1:0];
            o_clip  = 1'b1;
        end else if (i_value < MIN_V) begin
            o_value = MIN_V[COMP_W-1:0];
            o_clip  = 1'b1;
        end else begin
            o_value = i_value[COMP_W-1:0];
            o_clip  = 1'b0;
        end
    end

endmodule

### rtl/core/quaternion_vector_rotate.sv
// quaternion vector rotation, five-stage fixed-point pipeline
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: quat x,y,z,w, vec x,y,z
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: rot x,y,z; tuser: clipped
//
// one beat per cycle sustained while the sink is ready; each beat passes through r1 to r5 to the output
// the stages are the two multiplier stages, the dot/norm adder, the final sum
// and the output clamp
// each stage holds its beat until the next one frees, so bubbles close up under stall
// synchronous active-low reset clears only the stage valid bits
module quaternion_vector_rotate #(
    parameter int COMP_WIDTH     = qvr_pkg::COMP_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z, zero pad
    input  logic [((7*COMP_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // rot_x, rot_y, rot_z, zero pad
    output logic [((3*COMP_WIDTH+7)/8)*8-1:0]    o_m_axis_tdata,
    // clipped
    output logic                                 o_m_axis_tuser
);

    localparam int W      = COMP_WIDTH;
    localparam int L      = qvr_pkg::LANES;
    localparam int P_W    = 2 * W;
    localparam int CR_W   = 2 * W + 1;
    localparam int D_W    = 2 * W + 2;
    localparam int A_W    = W + D_W;
    localparam int C_W    = W + CR_W;
    localparam int ACC_W  = (3 * W + 5 > 2 * QUAT_FRAC_BITS + 2) ?
                            3 * W + 5 : 2 * QUAT_FRAC_BITS + 2;
    localparam int SHIFT  = 2 * QUAT_FRAC_BITS;
    localparam int OUT_W  = ((3 * W + 7) / 8) * 8;
    localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (SHIFT - 1);

    logic en1, en2, en3, en4, en5;

    logic signed [W-1:0] in_u [L];
    logic signed [W-1:0] in_v [L];
    logic signed [W-1:0] in_s;

    // stage 1: pairwise products
    logic                   r1_v;
    logic signed [P_W-1:0]  r1_uu [L];
    logic signed [P_W-1:0]  r1_uv [L];
    logic signed [CR_W-1:0] r1_cr [L];
    logic signed [P_W-1:0]  r1_ss;
    logic signed [W-1:0]    r1_u [L];
    logic signed [W-1:0]    r1_vv [L];
    logic signed [W-1:0]    r1_s;
    // stage 2: dot and norm
    logic                   r2_v;
    logic signed [D_W-1:0]  r2_dot;
    logic signed [D_W-1:0]  r2_nrm;
    logic signed [CR_W-1:0] r2_cr [L];
    logic signed [W-1:0]    r2_u [L];
    logic signed [W-1:0]    r2_vv [L];
    logic signed [W-1:0]    r2_s;
    // stage 3: triple products
    logic                   r3_v;
    logic signed [A_W-1:0]  r3_a [L];
    logic signed [A_W-1:0]  r3_b [L];
    logic signed [C_W-1:0]  r3_c [L];
    // stage 4: rounded and rescaled sums
    logic                   r4_v;
    logic signed [ACC_W-1:0] r4_sh [L];
    // stage 5: output register
    logic                   r5_v;
    logic signed [W-1:0]    r5_rot [L];
    logic                   r5_clip;

    logic signed [ACC_W-1:0] n4_sh [L];
    logic signed [W-1:0]     sat_val [L];
    logic [L-1:0]            sat_clip;

    assign en5 = !r5_v || i_m_axis_tready;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign o_s_axis_tready = en1;

    always_comb begin
        for (int i = 0; i < L; i++) begin
            in_u[i] = $signed(i_s_axis_tdata[W*i +: W]);
            in_v[i] = $signed(i_s_axis_tdata[W*(i+4) +: W]);
        end
        in_s = $signed(i_s_axis_tdata[W*3 +: W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_s_axis_tvalid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_s_axis_tvalid) begin
            for (int i = 0; i < L; i++) begin
                r1_uu[i] <= P_W'(in_u[i]) * P_W'(in_u[i]);
                r1_uv[i] <= P_W'(in_u[i]) * P_W'(in_v[i]);
                r1_cr[i] <= CR_W'(in_u[(i+1)%L]) * CR_W'(in_v[(i+2)%L])
                          - CR_W'(in_u[(i+2)%L]) * CR_W'(in_v[(i+1)%L]);
                r1_u[i]  <= in_u[i];
                r1_vv[i] <= in_v[i];
            end
            r1_ss <= P_W'(in_s) * P_W'(in_s);
            r1_s  <= in_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r1_v) begin
            r2_dot <= D_W'(r1_uv[0]) + D_W'(r1_uv[1]) + D_W'(r1_uv[2]);
            r2_nrm <= D_W'(r1_ss) - D_W'(r1_uu[0]) - D_W'(r1_uu[1]) - D_W'(r1_uu[2]);
            r2_cr  <= r1_cr;
            r2_u   <= r1_u;
            r2_vv  <= r1_vv;
            r2_s   <= r1_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r2_v) begin
            for (int i = 0; i < L; i++) begin
                r3_a[i] <= A_W'(r2_u[i]) * A_W'(r2_dot);
                r3_b[i] <= A_W'(r2_vv[i]) * A_W'(r2_nrm);
                r3_c[i] <= C_W'(r2_s) * C_W'(r2_cr[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < L; i++) begin
            n4_sh[i] = ((ACC_W'(r3_a[i]) <<< 1) + ACC_W'(r3_b[i])
                      + (ACC_W'(r3_c[i]) <<< 1) + HALF) >>> SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r3_v) begin
            r4_sh <= n4_sh;
        end
    end

    for (genvar g = 0; g < L; g++) begin : g_sat
        qvr_sat #(
            .ACC_W  (ACC_W),
            .COMP_W (W)
        ) u_sat (
            .i_value (r4_sh[g]),
            .o_value (sat_val[g]),
            .o_clip  (sat_clip[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en5 && r4_v) begin
            r5_rot  <= sat_val;
            r5_clip <= |sat_clip;
        end
    end

    assign o_m_axis_tvalid = r5_v;
    assign o_m_axis_tdata  = OUT_W'({r5_rot[2], r5_rot[1], r5_rot[0]});
    assign o_m_axis_tuser  = r5_clip;

endmodule
